// ===== rtl/drb_pkg.sv =====
package drb_pkg;

	localparam int unsigned PIX_W = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned D2_W = 12;
	localparam int unsigned FALL_W = 7;
	localparam int unsigned FALL_FULL = 64;
	localparam int unsigned FALL_SCALE = 1024;
	localparam int unsigned TAB_N = 256;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SKY_TOP = 2'd3;

	localparam logic [PIX_W-1:0] CENTER_X_RST = 8'd72;
	localparam logic [PIX_W-1:0] CENTER_Y_RST = 8'd84;
	localparam logic [1:0] TOP_BITS = 2'b11;

	localparam logic [3:0] BAYER_BASE [4][4] = '{
		'{4'd0, 4'd8, 4'd2, 4'd10},
		'{4'd12, 4'd4, 4'd14, 4'd6},
		'{4'd3, 4'd11, 4'd1, 4'd9},
		'{4'd15, 4'd7, 4'd13, 4'd5}
	};

	typedef struct packed {
		logic hit;
		logic [D2_W-1:0] d2;
		logic [5:0] thr;
		logic [PIX_W-1:0] pix;
	} drb_dist_t;

	function automatic logic [5:0] bayer8(input logic [2:0] row, input logic [2:0] col);
		logic [1:0] add;
		add = (row[2] && col[2]) ? 2'd1 : ({row[2], 1'b0} + (col[2] ? 2'd3 : 2'd0));
		return {BAYER_BASE[row[1:0]][col[1:0]], 2'b00} + {4'd0, add};
	endfunction

endpackage

// ===== rtl/dithered_radial_bloom_pixel_unit.sv =====
// Radial glow with ordered 8x8 dither on a stream of 2:2:2 pixels.
//
// Input requests arrive on the s_axis channel: tdata carries pixel_x in
// bits 7..0, pixel_y in bits 15..8 and the colour byte in bits 23..16.
// Each request gives exactly one result on the m_axis channel, whose tdata
// is the resulting colour byte.
//
// The block is a three-register pipeline: an input register, a register
// after the distance and dither threshold, and the result register.
// m_axis_tvalid rises once a request has passed the input register and the
// middle register into the result register, and one pixel is accepted in
// every cycle as long as the receiver keeps taking results.
// Each stage advances on its own when the stage after it is empty or moving,
// so a stalled receiver fills the pipeline before s_axis_tready falls.
//
// The configuration registers are written through cfg_we, cfg_index and
// cfg_data and should only change while no request is in flight.
// Reset empties the pipeline and loads the centre (72, 84), zero intensity
// and a sky top of row zero, so every pixel passes through unchanged.
module dithered_radial_bloom_pixel_unit import drb_pkg::*; #(
	parameter int GLOW_RADIUS = 24,
	parameter int SCREEN_WIDTH = 144,
	parameter int SCREEN_HEIGHT = 168
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// pixel_x [7:0], pixel_y [15:8], pixel_in [23:16]
	input  logic [23:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// pixel_out [7:0]
	output logic [7:0] m_axis_tdata,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PIX_W-1:0] cfg_data
);

	logic [PIX_W-1:0] center_x_q;
	logic [PIX_W-1:0] center_y_q;
	logic [PIX_W-1:0] intensity_q;
	logic [PIX_W-1:0] sky_top_q;

	logic v1_s1;
	logic v2_s2;
	logic vo_q;
	logic en1;
	logic en2;
	logic en_out;

	logic [PIX_W-1:0] x_s1;
	logic [PIX_W-1:0] y_s1;
	logic [PIX_W-1:0] pix_s1;
	drb_dist_t dist_c;
	drb_dist_t dist_s2;
	logic [PIX_W-1:0] shade_c;
	logic [PIX_W-1:0] out_q;

	assign en_out = !vo_q || m_axis_tready;
	assign en2 = !v2_s2 || en_out;
	assign en1 = !v1_s1 || en2;
	assign s_axis_tready = en1;
	assign m_axis_tvalid = vo_q;
	assign m_axis_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			intensity_q <= '0;
			sky_top_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTER_X: center_x_q <= cfg_data;
				CFG_CENTER_Y: center_y_q <= cfg_data;
				CFG_INTENSITY: intensity_q <= cfg_data;
				CFG_SKY_TOP: sky_top_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en1) v1_s1 <= s_axis_tvalid;
			if (en2) v2_s2 <= v1_s1;
			if (en_out) vo_q <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_axis_tvalid) begin
			x_s1 <= s_axis_tdata[7:0];
			y_s1 <= s_axis_tdata[15:8];
			pix_s1 <= s_axis_tdata[23:16];
		end
		if (en2 && v1_s1) dist_s2 <= dist_c;
		if (en_out && v2_s2) out_q <= shade_c;
	end

	drb_dist #(
		.GLOW_RADIUS(GLOW_RADIUS),
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_dist (
		.pixel_x(x_s1),
		.pixel_y(y_s1),
		.pixel_in(pix_s1),
		.center_x(center_x_q),
		.center_y(center_y_q),
		.sky_top_row(sky_top_q),
		.geom(dist_c)
	);

	drb_shade #(
		.GLOW_RADIUS(GLOW_RADIUS)
	) u_shade (
		.geom(dist_s2),
		.glow_intensity(intensity_q),
		.pixel_out(shade_c)
	);

	// An empty input stage must always take a new request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_s1 |-> s_axis_tready)
		else $error("input stage empty but not ready");

	// A pixel outside the glow leaves the pipeline unchanged.
	a_miss_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(en_out && v2_s2 && !dist_s2.hit) |=> (m_axis_tdata == $past(dist_s2.pix)))
		else $error("pixel outside glow was altered");

	// With zero intensity every pixel passes through.
	a_zero_intensity: assert property (@(posedge clk) disable iff (!arst_n)
		(en_out && v2_s2 && (intensity_q == '0)) |=> (m_axis_tdata == $past(dist_s2.pix)))
		else $error("pixel altered with glow disabled");

	// A full result register under stall keeps the full middle stage from moving.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vo_q && !m_axis_tready && v2_s2) |-> !en2)
		else $error("middle stage advanced into a stalled result");

endmodule

// ===== rtl/drb_dist.sv =====
module drb_dist import drb_pkg::*; #(
	parameter int GLOW_RADIUS = 24,
	parameter int SCREEN_WIDTH = 144,
	parameter int SCREEN_HEIGHT = 168
) (
	input  logic [PIX_W-1:0] pixel_x,
	input  logic [PIX_W-1:0] pixel_y,
	input  logic [PIX_W-1:0] pixel_in,
	input  logic [PIX_W-1:0] center_x,
	input  logic [PIX_W-1:0] center_y,
	input  logic [PIX_W-1:0] sky_top_row,
	output drb_dist_t geom
);

	localparam logic [10:0] SW = SCREEN_WIDTH[10:0];
	localparam logic [10:0] SH = SCREEN_HEIGHT[10:0];
	localparam logic [8:0] RAD = GLOW_RADIUS[8:0];
	localparam logic [12:0] R2 = 13'(GLOW_RADIUS * GLOW_RADIUS);

	logic signed [8:0] dx;
	logic signed [8:0] dy;
	logic [8:0] ax;
	logic [8:0] ay;
	logic [12:0] d2;
	logic on_screen;
	logic in_box;

	always_comb begin
		dx = $signed({1'b0, pixel_x}) - $signed({1'b0, center_x});
		dy = $signed({1'b0, pixel_y}) - $signed({1'b0, center_y});
		ax = dx[8] ? 9'(-dx) : 9'(dx);
		ay = dy[8] ? 9'(-dy) : 9'(dy);
		d2 = ({7'd0, ax[5:0]} * {7'd0, ax[5:0]}) + ({7'd0, ay[5:0]} * {7'd0, ay[5:0]});
		on_screen = ({3'd0, pixel_x} < SW) && ({3'd0, pixel_y} < SH);
		in_box = (ax <= RAD) && (ay <= RAD);
		geom.hit = on_screen && (pixel_y >= sky_top_row) && in_box && (d2 <= R2);
		geom.d2 = d2[D2_W-1:0];
		geom.thr = bayer8(pixel_y[2:0], pixel_x[2:0]);
		geom.pix = pixel_in;
	end

endmodule

// ===== rtl/drb_shade.sv =====
module drb_shade import drb_pkg::*; #(
	parameter int GLOW_RADIUS = 24
) (
	input  drb_dist_t geom,
	input  logic [PIX_W-1:0] glow_intensity,
	output logic [PIX_W-1:0] pixel_out
);

	localparam int unsigned R2 = GLOW_RADIUS * GLOW_RADIUS;

	logic [FALL_W-1:0] fall_tab [TAB_N];
	logic [FALL_W-1:0] fall;
	logic [14:0] prod;
	logic [9:0] v;
	logic inc;
	logic [2:0] lsum;
	logic [1:0] lvl;
	logic [2:0] rr;
	logic [2:0] gg;
	logic [2:0] bb;

	for (genvar i = 0; i < TAB_N; i++) begin : g_tab
		localparam int unsigned SUB = (i * FALL_SCALE) / R2;
		assign fall_tab[i] = (SUB >= FALL_FULL) ? '0 : FALL_W'(FALL_FULL - SUB);
	end

	always_comb begin
		fall = fall_tab[geom.d2[D2_W-1:4]];
		prod = {8'd0, fall} * {7'd0, glow_intensity};
		v = prod[13:4];
		inc = {v[3:0], 2'b00} > geom.thr;
		lsum = {1'b0, v[5:4]} + {2'd0, inc};
		lvl = ((|v[9:6]) || lsum[2] || (lsum[1:0] == 2'd3)) ? 2'd3 : lsum[1:0];
		rr = {1'b0, geom.pix[5:4]} + {1'b0, lvl};
		gg = {1'b0, geom.pix[3:2]} + {1'b0, lvl};
		bb = {1'b0, geom.pix[1:0]} + {1'b0, lvl};
		if (geom.hit && (lvl != 2'd0)) begin
			pixel_out = {TOP_BITS,
				(rr[2] ? 2'd3 : rr[1:0]),
				(gg[2] ? 2'd3 : gg[1:0]),
				(bb[2] ? 2'd3 : bb[1:0])};
		end else begin
			pixel_out = geom.pix;
		end
	end

endmodule
